// ----- rtl/core/circle_tile_coverage_penetration_macros.svh -----
// Assertion macros used by the circle tile coverage top level.
`ifndef CIRCLE_TILE_COVERAGE_PENETRATION_MACROS_SVH
`define CIRCLE_TILE_COVERAGE_PENETRATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTCP_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ctcp assertion failed");

// Next-cycle implication, disabled during reset.
`define CTCP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ctcp assertion failed");

`endif

// ----- rtl/core/ctcp_pkg.sv -----
// Types and constants of the circle tile coverage block.
package ctcp_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int DIM_W      = 9;
    localparam int COORD_W    = 17;
    localparam int RAD_W      = 10;
    localparam int EDGE_W     = 20;
    localparam int D_W        = 12;
    localparam int D2_W       = 22;
    localparam int SQ_STAGES  = 11;
    localparam int Q_BITS     = 10;
    localparam int MAG_W      = 21;
    localparam int PEN_W      = 18;
    localparam int TILE_W     = 16;

    localparam logic [DIM_W-1:0] MAX_MAP_DIM = 9'd256;
    localparam logic [RAD_W-1:0] RAD_MAX     = 10'd768;

    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        KIND_TILE   = 3'd0,
        KIND_LEFT   = 3'd1,
        KIND_RIGHT  = 3'd2,
        KIND_TOP    = 3'd3,
        KIND_BOTTOM = 3'd4
    } kind_t;

    // One token in flight: a bound hit, a tile candidate or the end marker.
    typedef struct packed {
        logic                      vld;
        logic                      is_end;
        kind_t                     kind;
        logic [TILE_W-1:0]         tile;
        logic signed [PEN_W-1:0]   px;
        logic signed [PEN_W-1:0]   py;
        logic [RAD_W-1:0]          r;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [DIM_W-1:0]          ci;
        logic [DIM_W-1:0]          cj;
        logic                      hit;
        logic                      zero;
        logic signed [D_W-1:0]     dx;
        logic signed [D_W-1:0]     dy;
    } tok_t;

endpackage

// ----- rtl/core/ctcp_tile_pipe.sv -----
// Tile test pipeline: offset, squares, compare, square root, product, magnitude, divide, output.
module ctcp_tile_pipe
    import ctcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  tok_t in_tok,
    output tok_t out_tok
);

    // stage 1: offset to closest point
    tok_t s1_reg, s1_next;
    // stage 2: squares
    tok_t s2_reg;
    logic [20:0] sqx_reg, sqy_reg;
    logic [19:0] rr_reg;
    // stage 3: distance squared and hit test
    tok_t s3_reg, s3_next;
    logic [D2_W-1:0] d2_reg;
    // square root stages
    tok_t              sq_tok_reg  [SQ_STAGES];
    logic [12:0]       sq_rem_reg  [SQ_STAGES];
    logic [10:0]       sq_root_reg [SQ_STAGES];
    logic [D2_W-1:0]   sq_val_reg  [SQ_STAGES];
    logic [12:0]       sq_rem_next [SQ_STAGES];
    logic [10:0]       sq_root_next[SQ_STAGES];
    logic [D2_W-1:0]   sq_val_next [SQ_STAGES];
    // numerator stage
    tok_t                 mu_reg;
    logic signed [24:0]   nx_reg, ny_reg;
    logic [10:0]          dist_reg;
    // magnitude stage
    tok_t                 mg_reg;
    logic [MAG_W-1:0]     mx_reg, my_reg;
    logic                 negx_reg, negy_reg;
    logic [10:0]          mdist_reg;
    // divider stages
    tok_t                 dv_tok_reg [Q_BITS];
    logic [MAG_W-1:0]     dv_rx_reg  [Q_BITS];
    logic [MAG_W-1:0]     dv_ry_reg  [Q_BITS];
    logic [Q_BITS-1:0]    dv_qx_reg  [Q_BITS];
    logic [Q_BITS-1:0]    dv_qy_reg  [Q_BITS];
    logic                 dv_nx_reg  [Q_BITS];
    logic                 dv_ny_reg  [Q_BITS];
    logic [10:0]          dv_d_reg   [Q_BITS];
    logic [MAG_W-1:0]     dv_rx_next [Q_BITS];
    logic [MAG_W-1:0]     dv_ry_next [Q_BITS];
    logic [Q_BITS-1:0]    dv_qx_next [Q_BITS];
    logic [Q_BITS-1:0]    dv_qy_next [Q_BITS];
    // output stage
    tok_t fin_reg, fin_next;

    logic signed [18:0] lox, hix, loy, hiy, cxe, cye, clx, cly, dx19, dy19;
    logic signed [23:0] psx, psy;
    logic [D2_W-1:0]    d2_sum;
    logic [10:0]        dist1;
    logic signed [12:0] dm;
    logic signed [24:0] nx_p, ny_p;
    logic signed [PEN_W-1:0] qxs, qys;

    always_comb
    begin
        lox  = {2'b00, in_tok.ci, 8'h00};
        hix  = {1'b0, {1'b0, in_tok.ci} + 10'd1, 8'h00};
        loy  = {2'b00, in_tok.cj, 8'h00};
        hiy  = {1'b0, {1'b0, in_tok.cj} + 10'd1, 8'h00};
        cxe  = {{2{in_tok.cx[COORD_W-1]}}, in_tok.cx};
        cye  = {{2{in_tok.cy[COORD_W-1]}}, in_tok.cy};
        clx  = (cxe < lox) ? lox : ((cxe > hix) ? hix : cxe);
        cly  = (cye < loy) ? loy : ((cye > hiy) ? hiy : cye);
        dx19 = clx - cxe;
        dy19 = cly - cye;
        s1_next      = in_tok;
        s1_next.dx   = dx19[D_W-1:0];
        s1_next.dy   = dy19[D_W-1:0];
        s1_next.zero = (dx19 == 19'sd0) && (dy19 == 19'sd0);
    end

    assign psx = s1_reg.dx * s1_reg.dx;
    assign psy = s1_reg.dy * s1_reg.dy;

    always_comb
    begin
        d2_sum  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        s3_next = s2_reg;
        if (s2_reg.kind == KIND_TILE)
        begin
            s3_next.hit = s2_reg.zero || (d2_sum <= {2'b00, rr_reg});
        end
    end

    // one root bit per stage
    always_comb
    begin
        logic [14:0] r4;
        logic [14:0] trial;
        logic [12:0] rem_src;
        logic [10:0] root_src;
        logic [D2_W-1:0] val_src;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_src  = '0;
                root_src = '0;
                val_src  = d2_reg;
            end
            else
            begin
                rem_src  = sq_rem_reg[k-1];
                root_src = sq_root_reg[k-1];
                val_src  = sq_val_reg[k-1];
            end
            r4    = {rem_src, val_src[D2_W-1 -: 2]};
            trial = {2'b00, root_src, 2'b01};
            if (r4 >= trial)
            begin
                sq_rem_next[k]  = 13'(r4 - trial);
                sq_root_next[k] = {root_src[9:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = r4[12:0];
                sq_root_next[k] = {root_src[9:0], 1'b0};
            end
            sq_val_next[k] = {val_src[D2_W-3:0], 2'b00};
        end
    end

    always_comb
    begin
        dist1 = (sq_root_reg[SQ_STAGES-1] == 11'd0) ? 11'd1 : sq_root_reg[SQ_STAGES-1];
        dm    = $signed({2'b00, dist1}) - $signed({3'b000, sq_tok_reg[SQ_STAGES-1].r});
        nx_p  = sq_tok_reg[SQ_STAGES-1].dx * dm;
        ny_p  = sq_tok_reg[SQ_STAGES-1].dy * dm;
    end

    // one quotient bit per stage, most significant first
    always_comb
    begin
        logic [MAG_W-1:0] rx_src, ry_src, dsh;
        logic [Q_BITS-1:0] qx_src, qy_src;
        logic [10:0] d_src;
        for (int k = 0; k < Q_BITS; k++)
        begin
            if (k == 0)
            begin
                rx_src = mx_reg;
                ry_src = my_reg;
                qx_src = '0;
                qy_src = '0;
                d_src  = mdist_reg;
            end
            else
            begin
                rx_src = dv_rx_reg[k-1];
                ry_src = dv_ry_reg[k-1];
                qx_src = dv_qx_reg[k-1];
                qy_src = dv_qy_reg[k-1];
                d_src  = dv_d_reg[k-1];
            end
            dsh = MAG_W'(d_src) << (Q_BITS - 1 - k);
            dv_rx_next[k] = (rx_src >= dsh) ? (rx_src - dsh) : rx_src;
            dv_ry_next[k] = (ry_src >= dsh) ? (ry_src - dsh) : ry_src;
            dv_qx_next[k] = {qx_src[Q_BITS-2:0], rx_src >= dsh};
            dv_qy_next[k] = {qy_src[Q_BITS-2:0], ry_src >= dsh};
        end
    end

    always_comb
    begin
        qxs = PEN_W'(dv_qx_reg[Q_BITS-1]);
        qys = PEN_W'(dv_qy_reg[Q_BITS-1]);
        fin_next = dv_tok_reg[Q_BITS-1];
        if (dv_tok_reg[Q_BITS-1].kind == KIND_TILE)
        begin
            if (dv_tok_reg[Q_BITS-1].zero)
            begin
                fin_next.px = PEN_W'(dv_tok_reg[Q_BITS-1].r);
                fin_next.py = '0;
            end
            else
            begin
                fin_next.px = dv_nx_reg[Q_BITS-1] ? -qxs : qxs;
                fin_next.py = dv_ny_reg[Q_BITS-1] ? -qys : qys;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            mu_reg  <= '0;
            mg_reg  <= '0;
            fin_reg <= '0;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_tok_reg[k] <= '0;
            end
            for (int k = 0; k < Q_BITS; k++)
            begin
                dv_tok_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s1_reg;
            s3_reg  <= s3_next;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_tok_reg[k] <= (k == 0) ? s3_reg : sq_tok_reg[k-1];
            end
            mu_reg  <= sq_tok_reg[SQ_STAGES-1];
            mg_reg  <= mu_reg;
            for (int k = 0; k < Q_BITS; k++)
            begin
                dv_tok_reg[k] <= (k == 0) ? mg_reg : dv_tok_reg[k-1];
            end
            fin_reg <= fin_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg  <= psx[20:0];
            sqy_reg  <= psy[20:0];
            rr_reg   <= s1_reg.r * s1_reg.r;
            d2_reg   <= d2_sum;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
                sq_val_reg[k]  <= sq_val_next[k];
            end
            nx_reg   <= nx_p;
            ny_reg   <= ny_p;
            dist_reg <= dist1;
            negx_reg <= nx_reg[24];
            negy_reg <= ny_reg[24];
            mx_reg   <= nx_reg[24] ? MAG_W'(-nx_reg) : nx_reg[MAG_W-1:0];
            my_reg   <= ny_reg[24] ? MAG_W'(-ny_reg) : ny_reg[MAG_W-1:0];
            mdist_reg <= dist_reg;
            for (int k = 0; k < Q_BITS; k++)
            begin
                dv_rx_reg[k] <= dv_rx_next[k];
                dv_ry_reg[k] <= dv_ry_next[k];
                dv_qx_reg[k] <= dv_qx_next[k];
                dv_qy_reg[k] <= dv_qy_next[k];
                dv_nx_reg[k] <= (k == 0) ? negx_reg : dv_nx_reg[k-1];
                dv_ny_reg[k] <= (k == 0) ? negy_reg : dv_ny_reg[k-1];
                dv_d_reg[k]  <= (k == 0) ? mdist_reg : dv_d_reg[k-1];
            end
        end
    end

    assign out_tok = fin_reg;

endmodule

// ----- rtl/core/circle_tile_coverage_penetration.sv -----
// Top level of the circle tile coverage and penetration block.
// Accepts one circle per transaction on the slave stream and returns, on the
// master stream, one transaction per map edge the circle extends past (left,
// right, top, bottom) and then one per unit tile inside the radius, rows top
// to bottom and columns left to right, with tlast on the final one. A circle
// with no edge or tile hit returns no transaction. A sequencer issues the four
// bound checks, then each tile of the clamped bounding rectangle (at most 49)
// and then an end marker, and holds the input until it is done; the next
// circle is taken while the earlier one still drains. Every candidate then
// flows through a 27-stage pipeline (offset, squares, compare, an 11-stage
// square root, a product stage, a magnitude stage, a 10-stage divider and an
// output stage) that accepts a token each cycle while the output is not
// stalled. Each result is held back until the next hit or the end marker
// leaves the pipeline, since tlast is known only then. Map width and height
// are written on the cfg channel, always ready; the user must write them only
// while no circle is in work, as the block itself does not enforce it.
module circle_tile_coverage_penetration
    import ctcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: [16:0] centre_x, [33:17] centre_y, [43:34] circle_radius
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // master stream: [15:0] tile_index, [33:16] pen_x, [51:34] pen_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // [2:0] hit_kind
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

`include "circle_tile_coverage_penetration_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BOUND = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t st_reg, st_next;

    logic [DIM_W-1:0] map_w_reg, map_h_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic [RAD_W-1:0] r_reg;
    logic [1:0] bsel_reg, bsel_next;
    logic [DIM_W-1:0] i_reg, i_next, j_reg, j_next;

    tok_t gen_reg, gen_next;
    tok_t pipe_out;

    tok_t pend_reg, pend_next;
    logic pend_vld_reg, pend_vld_next;
    logic m_vld_reg, m_vld_next;
    logic m_last_reg, m_last_next;
    tok_t m_tok_reg, m_tok_next;

    logic adv;
    logic accept;
    logic [DIM_W-1:0] wt, ht, minx, maxx, miny, maxy;
    logic signed [EDGE_W-1:0] cxe, cye, re, left, right, top, bottom, wf, hf;
    logic hit_l, hit_r, hit_t, hit_b, outside;
    logic [17:0] row_base;
    logic [TILE_W-1:0] tile;
    logic [RAD_W-1:0] r_in;

    // the whole pipeline moves whenever the output register can take a result
    assign adv       = !m_vld_reg || m_tready;
    assign s_tready  = (st_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign r_in = (s_tdata[43:34] > RAD_MAX) ? RAD_MAX : s_tdata[43:34];

    always_comb
    begin
        // clamp map size into one to the largest map dimension
        wt = (map_w_reg == '0) ? 9'd1 : ((map_w_reg > MAX_MAP_DIM) ? MAX_MAP_DIM : map_w_reg);
        ht = (map_h_reg == '0) ? 9'd1 : ((map_h_reg > MAX_MAP_DIM) ? MAX_MAP_DIM : map_h_reg);
        wf = {3'b000, wt, 8'h00};
        hf = {3'b000, ht, 8'h00};
        cxe = {{3{cx_reg[COORD_W-1]}}, cx_reg};
        cye = {{3{cy_reg[COORD_W-1]}}, cy_reg};
        re  = {10'b0, r_reg};
        left   = cxe - re;
        right  = cxe + re;
        top    = cye - re;
        bottom = cye + re;
        hit_l = left < 0;
        hit_r = right >= wf;
        hit_t = top < 0;
        hit_b = bottom >= hf;
        outside = (left >= wf) || (right < 0) || (top >= hf) || (bottom < 0);
        minx = hit_l ? 9'd0 : left[16:8];
        maxx = hit_r ? 9'(wt - 9'd1) : right[16:8];
        miny = hit_t ? 9'd0 : top[16:8];
        maxy = hit_b ? 9'(ht - 9'd1) : bottom[16:8];
        row_base = {9'b0, j_reg} * {9'b0, wt};
        tile = row_base[TILE_W-1:0] + {7'b0, i_reg};
    end

    // candidate sequencer
    always_comb
    begin
        st_next   = st_reg;
        bsel_next = bsel_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        gen_next        = '0;
        gen_next.kind   = KIND_TILE;
        gen_next.tile   = '0;
        gen_next.r      = r_reg;
        gen_next.cx     = cx_reg;
        gen_next.cy     = cy_reg;
        gen_next.ci     = i_reg;
        gen_next.cj     = j_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    st_next   = ST_BOUND;
                    bsel_next = 2'd0;
                end
            end
            ST_BOUND:
            begin
                gen_next.hit = 1'b1;
                case (bsel_reg)
                    2'd0:
                    begin
                        gen_next.vld  = hit_l;
                        gen_next.kind = KIND_LEFT;
                        gen_next.px   = PEN_W'(-left);
                    end
                    2'd1:
                    begin
                        gen_next.vld  = hit_r;
                        gen_next.kind = KIND_RIGHT;
                        gen_next.px   = PEN_W'(wf - right);
                    end
                    2'd2:
                    begin
                        gen_next.vld  = hit_t;
                        gen_next.kind = KIND_TOP;
                        gen_next.py   = PEN_W'(-top);
                    end
                    default:
                    begin
                        gen_next.vld  = hit_b;
                        gen_next.kind = KIND_BOTTOM;
                        gen_next.py   = PEN_W'(hf - bottom);
                    end
                endcase
                bsel_next = bsel_reg + 2'd1;
                if (bsel_reg == 2'd3)
                begin
                    st_next = outside ? ST_FIN : ST_WALK;
                    i_next  = minx;
                    j_next  = miny;
                end
            end
            ST_WALK:
            begin
                gen_next.vld  = 1'b1;
                gen_next.tile = tile;
                if (i_reg == maxx)
                begin
                    i_next = minx;
                    j_next = j_reg + 9'd1;
                    if (j_reg == maxy)
                    begin
                        st_next = ST_FIN;
                    end
                end
                else
                begin
                    i_next = i_reg + 9'd1;
                end
            end
            ST_FIN:
            begin
                // end marker closes the circle
                gen_next.vld    = 1'b1;
                gen_next.is_end = 1'b1;
                st_next         = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            bsel_reg  <= 2'd0;
            gen_reg   <= '0;
            map_w_reg <= MAX_MAP_DIM;
            map_h_reg <= MAX_MAP_DIM;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  map_w_reg <= cfg_data;
                    CFG_MAP_HEIGHT: map_h_reg <= cfg_data;
                    default:        map_w_reg <= map_w_reg;
                endcase
            end
            if (st_reg == ST_IDLE)
            begin
                st_reg   <= st_next;
                bsel_reg <= bsel_next;
                if (adv)
                begin
                    gen_reg <= gen_next;
                end
            end
            else if (adv)
            begin
                st_reg   <= st_next;
                bsel_reg <= bsel_next;
                gen_reg  <= gen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg <= s_tdata[16:0];
            cy_reg <= s_tdata[33:17];
            r_reg  <= r_in;
        end
        if (adv && (st_reg != ST_IDLE))
        begin
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    ctcp_tile_pipe u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_tok  (gen_reg),
        .out_tok (pipe_out)
    );

    // hold one hit back until the next hit or the end marker settles tlast
    always_comb
    begin
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        m_vld_next    = m_vld_reg;
        m_last_next   = m_last_reg;
        m_tok_next    = m_tok_reg;
        if (adv)
        begin
            m_vld_next = 1'b0;
            if (pipe_out.vld && pipe_out.is_end)
            begin
                if (pend_vld_reg)
                begin
                    m_vld_next  = 1'b1;
                    m_last_next = 1'b1;
                    m_tok_next  = pend_reg;
                end
                pend_vld_next = 1'b0;
            end
            else if (pipe_out.vld && pipe_out.hit)
            begin
                if (pend_vld_reg)
                begin
                    m_vld_next  = 1'b1;
                    m_last_next = 1'b0;
                    m_tok_next  = pend_reg;
                end
                pend_next     = pipe_out;
                pend_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            m_vld_reg    <= 1'b0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            m_vld_reg    <= m_vld_next;
            m_last_reg   <= m_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        m_tok_reg <= m_tok_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_tok_reg.kind;
    assign m_tdata  = {4'b0000, m_tok_reg.py, m_tok_reg.px, m_tok_reg.tile};

    // a taken circle starts its bound checks next cycle
    `CTCP_ASSERT_NEXT(a_accept_bound, clk, rst_n, accept, st_reg == ST_BOUND)
    // nothing stays held back once the closing result is shown
    `CTCP_ASSERT_IMPL(a_last_pend, clk, rst_n, m_vld_reg && m_last_reg, !pend_vld_reg)
    // the walk stays inside the clamped rectangle
    `CTCP_ASSERT_IMPL(a_walk_range, clk, rst_n, st_reg == ST_WALK,
        (i_reg <= maxx) && (j_reg <= maxy) && (i_reg >= minx))

endmodule
